[sv/epmr_pkg.sv]
// ----------------------------------------------------------------------------
// epmr_pkg : shared constants and types for the echo pulse median ranger
// Sizes of the sample batch, the width-to-distance scaler and the sequencer.
// ----------------------------------------------------------------------------
package epmr_pkg;

	localparam int SAMPLE_COUNT = 7;
	localparam int MEDIAN_IDX   = SAMPLE_COUNT / 2;

	localparam int TIME_W = 32;
	localparam int WID_W  = 16;   // saturated pulse width in us
	localparam int DIST_W = 14;   // distance in cm

	// floor(w * 10 / 61) is (w * DIST_RECIP) >> DIST_SHIFT for any 16-bit width
	localparam int RECIP_W    = 24;
	localparam int PROD_W     = WID_W + RECIP_W;
	localparam int DIST_SHIFT = 26;
	localparam logic [RECIP_W-1:0] DIST_RECIP =
		RECIP_W'(10 * ((2 ** DIST_SHIFT + 60) / 61));

	localparam int FILL_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int STEP_W = $clog2(SAMPLE_COUNT + 1);
	localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);

	typedef logic [DIST_W-1:0] dist_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCALE = 4'b0010,
		ST_STORE = 4'b0100,
		ST_RANK  = 4'b1000
	} state_t;

endpackage

[sv/echo_pulse_median_ranger.sv]
// ----------------------------------------------------------------------------
// echo_pulse_median_ranger : median-of-seven ultrasonic echo ranger
// Times echo pulses from pin edge events, turns each width into a distance
// and emits the median distance of every batch of seven.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    tdata / tuser
//  echo      in   echo_tvalid / echo_tready    tdata: time_us[31:0]; tuser: level
//  range     out  range_tvalid / range_tready  tdata: median_distance[13:0], pad
//
//  A rising edge or an ignored falling edge is handled in IDLE alone. A falling
//  edge that closes a pulse goes through width, reciprocal scale and store.
//  The edge that completes a batch adds a rank pass on the shared comparator:
//  each candidate is counted against the ring, at most 7 candidates in all.
//  arst_n clears the sequencer, arming, batch fill and the output valid flag.
//  A held-off range request stalls the rank pass only at its final step.
// ----------------------------------------------------------------------------
module echo_pulse_median_ranger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        echo_tvalid,
	output logic        echo_tready,
	input  logic [31:0] echo_tdata,   // [31:0] time_us
	input  logic        echo_tuser,   // [0] level
	output logic        range_tvalid,
	input  logic        range_tready,
	output logic [15:0] range_tdata   // [13:0] median_distance, [15:14] zero
);

	epmr_pkg::state_t state_q;

	logic                              armed_q;
	logic [epmr_pkg::TIME_W-1:0]       rise_q;
	logic [epmr_pkg::WID_W-1:0]        wid_q;
	epmr_pkg::dist_t                   quo_q;
	logic [epmr_pkg::FILL_W-1:0]       filled_q;
	logic [epmr_pkg::STEP_W-1:0]       step_q;
	logic [epmr_pkg::FILL_W-1:0]       round_q;
	logic [epmr_pkg::CNT_W-1:0]        lt_q;
	logic [epmr_pkg::CNT_W-1:0]        eq_q;
	epmr_pkg::dist_t                   cand_q;
	epmr_pkg::dist_t                   samples_q [epmr_pkg::SAMPLE_COUNT];
	logic                              out_valid_q;
	epmr_pkg::dist_t                   out_q;

	logic                              in_req;
	logic [epmr_pkg::TIME_W-1:0]       diff;
	logic [epmr_pkg::WID_W-1:0]        wid_sat;
	logic [epmr_pkg::PROD_W-1:0]       prod;
	epmr_pkg::dist_t                   cmp_a;
	epmr_pkg::dist_t                   cmp_b;
	logic                              cmp_lt;
	logic                              cmp_eq;
	logic [epmr_pkg::CNT_W:0]          rank_hi;
	logic                              found;
	logic                              out_busy;
	logic                              rotate;
	logic                              shift_in;
	logic                              emit;

	assign echo_tready  = (state_q == epmr_pkg::ST_IDLE);
	assign in_req       = echo_tvalid && echo_tready;
	assign range_tvalid = out_valid_q;
	assign range_tdata  = {2'b00, out_q};
	assign out_busy     = out_valid_q && !range_tready;

	// wrap-safe width, saturated to 16 bits
	assign diff    = echo_tdata - rise_q;
	assign wid_sat = (|diff[epmr_pkg::TIME_W-1:epmr_pkg::WID_W]) ? '1
		: diff[epmr_pkg::WID_W-1:0];

	// width * 10 / 61 by reciprocal multiplication
	assign prod = epmr_pkg::PROD_W'(wid_q) * epmr_pkg::PROD_W'(epmr_pkg::DIST_RECIP);

	// shared comparator for the rank pass
	assign cmp_a  = samples_q[0];
	assign cmp_b  = cand_q;
	assign cmp_lt = (cmp_a < cmp_b);
	assign cmp_eq = (cmp_a == cmp_b);

	assign rank_hi = {1'b0, lt_q} + {1'b0, eq_q};
	assign found   = (lt_q <= epmr_pkg::CNT_W'(epmr_pkg::MEDIAN_IDX))
		&& (rank_hi > (epmr_pkg::CNT_W + 1)'(epmr_pkg::MEDIAN_IDX));

	assign shift_in = (state_q == epmr_pkg::ST_STORE);
	assign rotate   = (state_q == epmr_pkg::ST_RANK)
		&& !((step_q == epmr_pkg::STEP_W'(epmr_pkg::SAMPLE_COUNT))
		&& (found || round_q == epmr_pkg::FILL_W'(epmr_pkg::SAMPLE_COUNT - 1)));
	assign emit     = (state_q == epmr_pkg::ST_RANK)
		&& (step_q == epmr_pkg::STEP_W'(epmr_pkg::SAMPLE_COUNT)) && !rotate && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= epmr_pkg::ST_IDLE;
			armed_q     <= 1'b0;
			rise_q      <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || out_busy;
			case (state_q)
				epmr_pkg::ST_IDLE: begin
					if (in_req) begin
						if (echo_tuser) begin
							armed_q <= 1'b1;
							rise_q  <= echo_tdata;
						end else if (armed_q) begin
							armed_q <= 1'b0;
							state_q <= epmr_pkg::ST_SCALE;
						end
					end
				end
				epmr_pkg::ST_SCALE: begin
					state_q <= epmr_pkg::ST_STORE;
				end
				epmr_pkg::ST_STORE: begin
					if (filled_q == epmr_pkg::FILL_W'(epmr_pkg::SAMPLE_COUNT - 1)) begin
						filled_q <= '0;
						state_q  <= epmr_pkg::ST_RANK;
					end else begin
						filled_q <= filled_q + 1'b1;
						state_q  <= epmr_pkg::ST_IDLE;
					end
				end
				epmr_pkg::ST_RANK: begin
					if (emit) begin
						state_q <= epmr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= epmr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			epmr_pkg::ST_IDLE: begin
				wid_q <= wid_sat;
			end
			epmr_pkg::ST_SCALE: begin
				quo_q <= prod[epmr_pkg::DIST_SHIFT + epmr_pkg::DIST_W - 1:epmr_pkg::DIST_SHIFT];
			end
			epmr_pkg::ST_STORE: begin
				step_q  <= '0;
				round_q <= '0;
			end
			epmr_pkg::ST_RANK: begin
				if (step_q == '0) begin
					cand_q <= samples_q[0];
					lt_q   <= '0;
					eq_q   <= epmr_pkg::CNT_W'(1);
					step_q <= step_q + 1'b1;
				end else if (step_q != epmr_pkg::STEP_W'(epmr_pkg::SAMPLE_COUNT)) begin
					if (cmp_lt) begin
						lt_q <= lt_q + 1'b1;
					end
					if (cmp_eq) begin
						eq_q <= eq_q + 1'b1;
					end
					step_q <= step_q + 1'b1;
				end else if (rotate) begin
					// next candidate sits at the head after this turn
					step_q  <= '0;
					round_q <= round_q + 1'b1;
				end else if (!out_busy) begin
					out_q <= cand_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sample ring: new distances shift in, the rank pass turns it
	always_ff @(posedge clk) begin
		for (int i = 0; i < epmr_pkg::SAMPLE_COUNT; i++) begin
			if (shift_in) begin
				samples_q[i] <= (i == 0) ? quo_q : samples_q[(i + epmr_pkg::SAMPLE_COUNT - 1)
					% epmr_pkg::SAMPLE_COUNT];
			end else if (rotate) begin
				samples_q[i] <= samples_q[(i + 1) % epmr_pkg::SAMPLE_COUNT];
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q < epmr_pkg::FILL_W'(epmr_pkg::SAMPLE_COUNT))
		else $error("batch fill count out of range");

	a_result_from_rank: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == epmr_pkg::ST_RANK))
		else $error("result raised outside the rank pass");

	a_rank_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == epmr_pkg::ST_RANK && step_q != '0)
		|-> rank_hi <= (epmr_pkg::CNT_W + 1)'(epmr_pkg::SAMPLE_COUNT))
		else $error("rank counts exceed batch size");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !range_tready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

[sim/echo_pulse_median_ranger_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// echo_pulse_median_ranger_check : scoreboard for the echo pulse median ranger
// Watches both stream channels, keeps its own arming, pulse timing and batch
// state, queues the median each completed batch should give and compares
// every range request against the oldest queued median.
// ----------------------------------------------------------------------------
module echo_pulse_median_ranger_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        echo_tvalid,
	input  logic        echo_tready,
	input  logic [31:0] echo_tdata,   // [31:0] time_us
	input  logic        echo_tuser,   // [0] level
	input  logic        range_tvalid,
	input  logic        range_tready,
	input  logic [15:0] range_tdata,  // [13:0] median_distance, [15:14] zero
	output int          fails,
	output int          pending,
	output int          medians,
	output int          saturated,
	output int          strays,
	output int          restarts
);

	localparam int WID_MAX   = 2 ** epmr_pkg::WID_W - 1;
	localparam int SCALE_MUL = 10;
	localparam int SCALE_DIV = 61;
	localparam int SHOW_MAX  = 10;

	logic                        armed = 1'b0;
	logic [epmr_pkg::TIME_W-1:0] rise_ts = '0;
	epmr_pkg::dist_t             batch [epmr_pkg::SAMPLE_COUNT];
	int                          fill = 0;
	epmr_pkg::dist_t             median_q [$];

	int n_fail, n_median, n_sat, n_stray, n_restart;

	function automatic epmr_pkg::dist_t batch_median();
		epmr_pkg::dist_t srt [epmr_pkg::SAMPLE_COUNT];
		epmr_pkg::dist_t key;
		int              j;
		srt = batch;
		for (int i = 1; i < epmr_pkg::SAMPLE_COUNT; i++) begin
			key = srt[i];
			j = i - 1;
			while (j >= 0 && srt[j] > key) begin
				srt[j + 1] = srt[j];
				j--;
			end
			srt[j + 1] = key;
		end
		return srt[epmr_pkg::MEDIAN_IDX];
	endfunction

	function automatic void predict_edge(logic lvl, logic [epmr_pkg::TIME_W-1:0] ts);
		logic [epmr_pkg::TIME_W-1:0] span;
		logic [epmr_pkg::WID_W-1:0]  wid;
		int                          scaled;
		if (lvl) begin
			// a second rise simply restarts the timing
			if (armed)
				n_restart++;
			armed = 1'b1;
			rise_ts = ts;
			return;
		end
		if (!armed) begin
			n_stray++;
			return;
		end
		armed = 1'b0;
		span = ts - rise_ts;
		if (span > epmr_pkg::TIME_W'(WID_MAX)) begin
			wid = '1;
			n_sat++;
		end else begin
			wid = span[epmr_pkg::WID_W-1:0];
		end
		scaled = int'(wid) * SCALE_MUL;
		batch[fill] = epmr_pkg::dist_t'(scaled / SCALE_DIV);
		fill++;
		if (fill == epmr_pkg::SAMPLE_COUNT) begin
			fill = 0;
			median_q.push_back(batch_median());
		end
	endfunction

	function automatic void check_median(logic [15:0] beat);
		epmr_pkg::dist_t want;
		if (median_q.size() == 0) begin
			n_fail++;
			if (n_fail <= SHOW_MAX)
				$display("%0t: range request with no median pending, got %0d",
					$time, beat[epmr_pkg::DIST_W-1:0]);
			return;
		end
		want = median_q.pop_front();
		n_median++;
		if (beat[epmr_pkg::DIST_W-1:0] !== want || beat[15:epmr_pkg::DIST_W] !== '0) begin
			n_fail++;
			if (n_fail <= SHOW_MAX)
				$display("%0t: median mismatch, expected %0d got %0d (pad %b)",
					$time, want, beat[epmr_pkg::DIST_W-1:0], beat[15:epmr_pkg::DIST_W]);
		end
	endfunction

	// handshakes are sampled with the values held just before the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed = 1'b0;
			rise_ts = '0;
			fill = 0;
			median_q.delete();
		end else begin
			// a median leaving now cannot come from an edge taken at this edge
			if (range_tvalid && range_tready)
				check_median(range_tdata);
			if (echo_tvalid && echo_tready)
				predict_edge(echo_tuser, echo_tdata);
		end
		fails     <= n_fail;
		pending   <= median_q.size();
		medians   <= n_median;
		saturated <= n_sat;
		strays    <= n_stray;
		restarts  <= n_restart;
	end

endmodule

[sim/echo_pulse_median_ranger_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// echo_pulse_median_ranger_test : stimulus and verdict for the echo ranger
// Drives echo edge requests (directed corner pulses, then random pulses with
// stray edges, restarts and long or wrapped widths) against a randomly
// stalling range sink, and reports the scoreboard's verdict.
// ----------------------------------------------------------------------------
module echo_pulse_median_ranger_test;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 7;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int HOLD_CYCLES   = 2000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int RANDOM_PULSES = 280;
	localparam int HOLD_PULSES   = 40;
	localparam int CALM_PULSES   = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        echo_tvalid = 1'b0;
	logic        echo_tready;
	logic [31:0] echo_tdata = '0;    // [31:0] time_us
	logic        echo_tuser = 1'b0;  // [0] level
	logic        range_tvalid;
	logic        range_tready = 1'b0;
	logic [15:0] range_tdata;        // [13:0] median_distance, [15:14] zero

	int fails, pending, medians, saturated, strays, restarts;
	int n_edges = 0;
	int cycles = 0;
	int hold_asked = 0;
	int hold_done = 0;
	bit gaps_on = 1'b1;

	always #HALF_PERIOD clk = ~clk;

	echo_pulse_median_ranger u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.echo_tvalid  (echo_tvalid),
		.echo_tready  (echo_tready),
		.echo_tdata   (echo_tdata),
		.echo_tuser   (echo_tuser),
		.range_tvalid (range_tvalid),
		.range_tready (range_tready),
		.range_tdata  (range_tdata)
	);

	echo_pulse_median_ranger_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.echo_tvalid  (echo_tvalid),
		.echo_tready  (echo_tready),
		.echo_tdata   (echo_tdata),
		.echo_tuser   (echo_tuser),
		.range_tvalid (range_tvalid),
		.range_tready (range_tready),
		.range_tdata  (range_tdata),
		.fails        (fails),
		.pending      (pending),
		.medians      (medians),
		.saturated    (saturated),
		.strays       (strays),
		.restarts     (restarts)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped at the cycle limit with %0d medians pending", pending);
			$display("FAILURE");
			$finish;
		end
	end

	// range sink: random back-pressure plus one long hold-off on request
	initial begin : range_sink
		int gap;
		@(posedge clk);
		forever begin
			if (hold_asked != hold_done) begin
				range_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				range_tready <= 1'b0;
				gap = $urandom_range(1, 5);
				repeat (gap) @(posedge clk);
			end else begin
				range_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// returns in the step of acceptance with tvalid still high
	task automatic send_edge(input logic lvl, input logic [31:0] ts);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			echo_tvalid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		echo_tvalid <= 1'b1;
		echo_tuser  <= lvl;
		echo_tdata  <= ts;
		@(posedge clk);
		while (!echo_tready)
			@(posedge clk);
		n_edges++;
	endtask

	task automatic send_pulse(input logic [31:0] t0, input logic [31:0] wid);
		send_edge(1'b1, t0);
		send_edge(1'b0, t0 + wid);
	endtask

	task automatic random_pulse();
		logic [31:0] wid;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			wid = $urandom_range(0, 65535);
		end else if (pick < 75) begin
			wid = $urandom_range(0, 700);
		end else if (pick < 83) begin
			wid = $urandom_range(65536, 300000);
		end else if (pick < 88) begin
			wid = $urandom;
		end else if (pick < 94) begin
			// falling edge with nothing armed, then a normal pulse
			send_edge(1'b0, $urandom);
			wid = $urandom_range(0, 65535);
		end else begin
			// early rise that the real rise then restarts
			send_edge(1'b1, $urandom);
			wid = $urandom_range(0, 65535);
		end
		send_pulse($urandom, wid);
	endtask

	task automatic drain();
		echo_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner pulses
		send_edge(1'b0, 32'h0000_1234);
		send_pulse(32'hFFFF_FFFF, 32'd0);
		send_pulse(32'h0000_0000, 32'hFFFF_FFFF);
		send_pulse(32'h1000_0000, 32'd65535);
		send_pulse(32'h2000_0000, 32'd65536);
		send_pulse(32'hFFFF_FFF0, 32'd32);
		send_edge(1'b1, 32'h3000_0000);
		send_pulse(32'h3000_0100, 32'd61);
		send_pulse(32'h4000_0000, 32'd60);
		send_pulse(32'h5555_AAAA, 32'd6);
		send_pulse(32'hAAAA_5555, 32'd1);
		send_edge(1'b0, 32'hAAAA_5555);

		repeat (RANDOM_PULSES) random_pulse();

		// long sink hold-off while edges keep coming, then wait for every median
		hold_asked++;
		repeat (HOLD_PULSES) random_pulse();
		drain();

		repeat (RANDOM_PULSES) random_pulse();

		gaps_on = 1'b0;
		repeat (CALM_PULSES) random_pulse();

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ranger run: %0d echo edge requests, %0d medians checked",
			n_edges, medians);
		$display("  %0d saturated widths, %0d stray falls, %0d timing restarts",
			saturated, strays, restarts);
		if (fails == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d medians still pending", fails, pending);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
